[rtl/gmlp_pkg.sv]
// ----------------------------------------------------------------------------
// gmlp_pkg
// Shared types and constants of the G-code move line parser.
// ----------------------------------------------------------------------------
package gmlp_pkg;

    localparam int LINE_COUNT_BITS     = 24;
    localparam int COMMAND_NUMBER_BITS = 31;
    localparam int CMD_OUT_BITS        = 31;
    localparam int COORD_BITS          = 21;
    localparam int ERR_BITS            = 4;
    localparam int WHOLE_BITS          = 11;
    localparam int FRAC_BITS           = 11;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;

    typedef enum logic [1:0] {
        TOK_FEED,
        TOK_LF,
        TOK_EOF
    } tok_kind_t;

    // held: a CR was pending when end of file arrived
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] ch;
        logic       held;
    } token_t;

    typedef enum logic [ERR_BITS-1:0] {
        ERR_OK          = 4'd0,
        ERR_NO_N        = 4'd1,
        ERR_BAD_NUMBER  = 4'd2,
        ERR_NOT_G01     = 4'd3,
        ERR_BAD_LETTER  = 4'd4,
        ERR_BAD_WHOLE   = 4'd5,
        ERR_NO_DOT      = 4'd6,
        ERR_SHORT_FRAC  = 4'd7,
        ERR_BAD_FRAC    = 4'd8,
        ERR_AXIS_ORDER  = 4'd9,
        ERR_NO_AXES     = 4'd10,
        ERR_FIRST_INCOMPLETE = 4'd11
    } err_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

[rtl/gmlp_in_if.sv]
// ----------------------------------------------------------------------------
// gmlp_in_if
// Text byte channel: valid/ready handshake with byte and end-of-file flag.
// ----------------------------------------------------------------------------
interface gmlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_file;

    modport source (output valid, output char_in, output end_of_file, input ready);
    modport sink   (input valid, input char_in, input end_of_file, output ready);
endinterface

[rtl/gmlp_out_if.sv]
// ----------------------------------------------------------------------------
// gmlp_out_if
// Command result channel: valid/ready handshake with one parsed line.
// ----------------------------------------------------------------------------
interface gmlp_out_if
    import gmlp_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [CMD_OUT_BITS-1:0]       command_number;
    logic signed [COORD_BITS-1:0]  x_milli;
    logic signed [COORD_BITS-1:0]  y_milli;
    logic signed [COORD_BITS-1:0]  z_milli;
    logic [LINE_COUNT_BITS-1:0]    line_number;
    logic [ERR_BITS-1:0]           error_code;

    modport source (output valid, output command_number, output x_milli, output y_milli,
                    output z_milli, output line_number, output error_code, input ready);
    modport sink   (input valid, input command_number, input x_milli, input y_milli,
                    input z_milli, input line_number, input error_code, output ready);
endinterface

[rtl/gmlp_front.sv]
// ----------------------------------------------------------------------------
// gmlp_front
// Accepts bytes, handles the held CR and turns each byte into parser tokens.
// ----------------------------------------------------------------------------
module gmlp_front
    import gmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gmlp_in_if.sink     in_ch,
    output logic        push,
    output token_t      push_tok,
    input  logic        full
);

    logic       held_reg, held_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_ch_reg, pend_ch_next;
    logic       acc;

    assign in_ch.ready = !pend_reg && !full;
    assign acc = in_ch.valid && in_ch.ready;

    always_comb
    begin
        held_next    = held_reg;
        pend_next    = pend_reg;
        pend_ch_next = pend_ch_reg;
        push         = 1'b0;
        push_tok     = '{kind: TOK_FEED, ch: in_ch.char_in, held: 1'b0};
        if (pend_reg)
        begin
            // byte that followed a released CR
            if (!full)
            begin
                push      = 1'b1;
                push_tok  = '{kind: TOK_FEED, ch: pend_ch_reg, held: 1'b0};
                pend_next = 1'b0;
            end
        end
        else if (acc)
        begin
            if (in_ch.end_of_file)
            begin
                push      = 1'b1;
                push_tok  = '{kind: TOK_EOF, ch: in_ch.char_in, held: held_reg};
                held_next = 1'b0;
            end
            else if (in_ch.char_in == CH_LF)
            begin
                push      = 1'b1;
                push_tok  = '{kind: TOK_LF, ch: in_ch.char_in, held: 1'b0};
                held_next = 1'b0;
            end
            else if (in_ch.char_in == CH_CR)
            begin
                if (held_reg)
                begin
                    push     = 1'b1;
                    push_tok = '{kind: TOK_FEED, ch: CH_CR, held: 1'b0};
                end
                held_next = 1'b1;
            end
            else if (held_reg)
            begin
                push         = 1'b1;
                push_tok     = '{kind: TOK_FEED, ch: CH_CR, held: 1'b0};
                held_next    = 1'b0;
                pend_next    = 1'b1;
                pend_ch_next = in_ch.char_in;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ch_reg <= pend_ch_next;
    end

endmodule

[rtl/gmlp_queue.sv]
// ----------------------------------------------------------------------------
// gmlp_queue
// Short token queue between front and back.
// ----------------------------------------------------------------------------
module gmlp_queue
    import gmlp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_tok,
    output logic   full,
    output logic   tok_valid,
    output token_t tok,
    input  logic   pop
);

    token_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_reg, rd_reg;
    logic [QUEUE_PTR_BITS:0]   cnt_reg;
    logic                      do_pop;

    assign full      = (cnt_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign tok_valid = (cnt_reg != '0);
    assign tok       = mem_reg[rd_reg];
    assign do_pop    = pop && tok_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_tok;
    end

endmodule

[rtl/gmlp_back.sv]
// ----------------------------------------------------------------------------
// gmlp_back
// Line parser: consumes tokens, keeps coordinates, registers each result.
// ----------------------------------------------------------------------------
module gmlp_back
    import gmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    input  token_t      tok,
    output logic        pop,
    gmlp_out_if.source  out_ch
);

    typedef enum logic [3:0] {
        PH_N, PH_NUM_START, PH_NUM_SIGN, PH_NUM_DIG, PH_G, PH_G0, PH_G1, PH_AXIS,
        PH_AFTER_LETTER, PH_W_START, PH_W_SIGN, PH_W_DIG, PH_DOT, PH_FRAC
    } phase_t;

    localparam int NUM_BITS = COMMAND_NUMBER_BITS + 1;
    localparam logic [NUM_BITS-1:0] CMD_MAX =
        NUM_BITS'((64'd1 << COMMAND_NUMBER_BITS) - 64'd1);
    localparam logic [NUM_BITS-1:0] CMD_CAP = CMD_MAX + 1'b1;
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
    localparam logic [WHOLE_BITS-1:0] WHOLE_CAP = WHOLE_BITS'(1000);

    phase_t                        phase_reg, phase_next;
    logic [LINE_COUNT_BITS-1:0]    lcnt_reg, lcnt_next;
    logic                          nonempty_reg, nonempty_next;
    logic [NUM_BITS-1:0]           num_reg, num_next;
    logic [WHOLE_BITS-1:0]         whole_reg, whole_next;
    logic                          minus_reg, minus_next;
    logic                          wneg_reg, wneg_next;
    logic [FRAC_BITS-1:0]          frac_reg, frac_next;
    logic [1:0]                    fchars_reg, fchars_next;
    logic [1:0]                    fstage_reg, fstage_next;
    logic                          fneg_reg, fneg_next;
    logic                          fgot_reg, fgot_next;
    logic [1:0]                    axis_reg, axis_next;
    logic [2:0]                    seen_reg, seen_next;
    logic signed [COORD_BITS-1:0]  coord_reg [3];
    logic signed [COORD_BITS-1:0]  coord_next [3];
    logic                          first_reg, first_next;
    logic                          halt_reg, halt_next;

    logic                          ovalid_reg, ovalid_next;
    logic [CMD_OUT_BITS-1:0]       ocmd_reg, ocmd_next;
    logic signed [COORD_BITS-1:0]  ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [LINE_COUNT_BITS-1:0]    oline_reg, oline_next;
    logic [ERR_BITS-1:0]           oerr_reg, oerr_next;

    always_comb
    begin
        logic                          take;
        logic [7:0]                    c;
        logic [3:0]                    d;
        err_t                          err;
        logic                          do_wstart, do_dot, do_close, num_ok;
        logic [NUM_BITS+3:0]           t;
        logic [WHOLE_BITS+3:0]         tw;
        logic [LINE_COUNT_BITS-1:0]    cur_line;
        logic [COORD_BITS-1:0]         mag;
        logic signed [COORD_BITS-1:0]  val;
        err_t                          cerr;

        phase_next    = phase_reg;
        lcnt_next     = lcnt_reg;
        nonempty_next = nonempty_reg;
        num_next      = num_reg;
        whole_next    = whole_reg;
        minus_next    = minus_reg;
        wneg_next     = wneg_reg;
        frac_next     = frac_reg;
        fchars_next   = fchars_reg;
        fstage_next   = fstage_reg;
        fneg_next     = fneg_reg;
        fgot_next     = fgot_reg;
        axis_next     = axis_reg;
        seen_next     = seen_reg;
        coord_next    = coord_reg;
        first_next    = first_reg;
        halt_next     = halt_reg;
        ovalid_next   = ovalid_reg && !out_ch.ready;
        ocmd_next     = ocmd_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        oline_next    = oline_reg;
        oerr_next     = oerr_reg;

        take      = tok_valid && !halt_reg && (!ovalid_reg || out_ch.ready);
        pop       = tok_valid && (halt_reg || !ovalid_reg || out_ch.ready);
        c         = tok.ch;
        d         = c[3:0];
        err       = ERR_OK;
        do_wstart = 1'b0;
        do_dot    = 1'b0;
        do_close  = 1'b0;
        num_ok    = (num_reg >= NUM_BITS'(1)) && (num_reg <= CMD_MAX);
        t         = num_reg * 4'd10 + (NUM_BITS+4)'(d);
        tw        = whole_reg * 4'd10 + (WHOLE_BITS+4)'(d);
        cur_line  = (lcnt_reg != LINE_MAX) ? lcnt_reg + 1'b1 : LINE_MAX;
        mag       = COORD_BITS'(whole_reg) * COORD_BITS'(1000);
        val       = '0;
        cerr      = ERR_OK;

        if (take)
        begin
            case (tok.kind)
                TOK_FEED:
                begin
                    nonempty_next = 1'b1;
                    case (phase_reg)
                        PH_N:
                            if (c == CH_N) phase_next = PH_NUM_START;
                            else if (!is_ws(c)) err = ERR_NO_N;
                        PH_NUM_START:
                            if (c == CH_PLUS) phase_next = PH_NUM_SIGN;
                            else if (is_dig(c))
                            begin
                                num_next   = NUM_BITS'(d);
                                phase_next = PH_NUM_DIG;
                            end
                            else if (!is_ws(c)) err = ERR_BAD_NUMBER;
                        PH_NUM_SIGN:
                            if (is_dig(c))
                            begin
                                num_next   = NUM_BITS'(d);
                                phase_next = PH_NUM_DIG;
                            end
                            else err = ERR_BAD_NUMBER;
                        PH_NUM_DIG:
                            if (is_dig(c))
                                num_next = (t > (NUM_BITS+4)'(CMD_CAP)) ? CMD_CAP
                                                                          : NUM_BITS'(t);
                            else if (!num_ok) err = ERR_BAD_NUMBER;
                            else if (c == CH_G) phase_next = PH_G0;
                            else if (is_ws(c)) phase_next = PH_G;
                            else err = ERR_NOT_G01;
                        PH_G:
                            if (c == CH_G) phase_next = PH_G0;
                            else if (!is_ws(c)) err = ERR_NOT_G01;
                        PH_G0:
                            if (c == CH_0) phase_next = PH_G1;
                            else if (!is_ws(c)) err = ERR_NOT_G01;
                        PH_G1:
                            if (c == CH_1) phase_next = PH_AXIS;
                            else if (!is_ws(c)) err = ERR_NOT_G01;
                        PH_AXIS:
                            if (c >= CH_X && c <= CH_Z)
                            begin
                                axis_next  = 2'(c - CH_X);
                                whole_next = '0;
                                wneg_next  = 1'b0;
                                minus_next = 1'b0;
                                phase_next = PH_AFTER_LETTER;
                            end
                            else if (!is_ws(c)) err = ERR_BAD_LETTER;
                        PH_AFTER_LETTER:
                        begin
                            minus_next = (c == CH_MINUS);
                            phase_next = PH_W_START;
                            do_wstart  = 1'b1;
                        end
                        PH_W_START:
                            do_wstart = 1'b1;
                        PH_W_SIGN:
                            if (is_dig(c))
                            begin
                                whole_next = WHOLE_BITS'(d);
                                phase_next = PH_W_DIG;
                            end
                            else err = ERR_BAD_WHOLE;
                        PH_W_DIG:
                            if (is_dig(c))
                                whole_next = (tw > (WHOLE_BITS+4)'(WHOLE_CAP)) ? WHOLE_CAP
                                                                               : WHOLE_BITS'(tw);
                            else if (whole_reg >= WHOLE_CAP) err = ERR_BAD_WHOLE;
                            else
                            begin
                                phase_next = PH_DOT;
                                do_dot     = 1'b1;
                            end
                        PH_DOT:
                            do_dot = 1'b1;
                        PH_FRAC:
                        begin
                            // three-byte window read like strtol
                            if (c == CH_NUL) fstage_next = 2'd3;
                            else
                            begin
                                case (fstage_reg)
                                    2'd0:
                                        if (c == CH_PLUS || c == CH_MINUS)
                                        begin
                                            fneg_next   = (c == CH_MINUS);
                                            fstage_next = 2'd1;
                                        end
                                        else if (is_dig(c))
                                        begin
                                            frac_next   = FRAC_BITS'(d);
                                            fgot_next   = 1'b1;
                                            fstage_next = 2'd2;
                                        end
                                        else if (!is_ws(c)) fstage_next = 2'd3;
                                    2'd1:
                                        if (is_dig(c))
                                        begin
                                            frac_next   = FRAC_BITS'(d);
                                            fgot_next   = 1'b1;
                                            fstage_next = 2'd2;
                                        end
                                        else fstage_next = 2'd3;
                                    2'd2:
                                        if (is_dig(c))
                                            frac_next = FRAC_BITS'(frac_reg * 4'd10
                                                                   + FRAC_BITS'(d));
                                        else fstage_next = 2'd3;
                                    default: ;
                                endcase
                            end
                            fchars_next = fchars_reg + 1'b1;
                            if (fchars_reg == 2'd2)
                            begin
                                if (!fgot_next || (fneg_next && frac_next != '0))
                                    err = ERR_BAD_FRAC;
                                else if ((axis_reg == 2'd0 && seen_reg[2:1] != 2'b00) ||
                                         (axis_reg == 2'd1 && seen_reg[2]))
                                    err = ERR_AXIS_ORDER;
                                else
                                begin
                                    val = wneg_reg ? -$signed(mag) : $signed(mag);
                                    val = minus_reg ? val - $signed(COORD_BITS'(frac_next))
                                                    : val + $signed(COORD_BITS'(frac_next));
                                    if (axis_reg != 2'd3)
                                        coord_next[axis_reg] = val;
                                    seen_next  = seen_reg | (3'b001 << axis_reg);
                                    phase_next = PH_AXIS;
                                end
                            end
                        end
                        default: ;
                    endcase

                    if (do_wstart)
                    begin
                        if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            wneg_next  = (c == CH_MINUS);
                            phase_next = PH_W_SIGN;
                        end
                        else if (is_dig(c))
                        begin
                            whole_next = WHOLE_BITS'(d);
                            phase_next = PH_W_DIG;
                        end
                        else if (!is_ws(c)) err = ERR_BAD_WHOLE;
                    end
                    if (do_dot)
                    begin
                        if (c == CH_DOT)
                        begin
                            frac_next   = '0;
                            fchars_next = '0;
                            fstage_next = '0;
                            fneg_next   = 1'b0;
                            fgot_next   = 1'b0;
                            phase_next  = PH_FRAC;
                        end
                        else if (!is_ws(c)) err = ERR_NO_DOT;
                    end

                    if (err != ERR_OK)
                    begin
                        halt_next   = 1'b1;
                        ovalid_next = 1'b1;
                        ocmd_next   = '0;
                        ox_next     = '0;
                        oy_next     = '0;
                        oz_next     = '0;
                        oline_next  = cur_line;
                        oerr_next   = err;
                    end
                end
                TOK_LF:
                    do_close = 1'b1;
                TOK_EOF:
                    do_close = nonempty_reg || tok.held;
                default: ;
            endcase

            if (do_close)
            begin
                case (phase_reg)
                    PH_N:                             cerr = ERR_NO_N;
                    PH_NUM_START, PH_NUM_SIGN:        cerr = ERR_BAD_NUMBER;
                    PH_NUM_DIG:                       cerr = num_ok ? ERR_NOT_G01
                                                                    : ERR_BAD_NUMBER;
                    PH_G, PH_G0, PH_G1:               cerr = ERR_NOT_G01;
                    PH_AXIS:
                        if (seen_reg == 3'b000) cerr = ERR_NO_AXES;
                        else if (!first_reg && seen_reg != 3'b111)
                            cerr = ERR_FIRST_INCOMPLETE;
                        else cerr = ERR_OK;
                    PH_AFTER_LETTER, PH_W_START, PH_W_SIGN: cerr = ERR_BAD_WHOLE;
                    PH_W_DIG:   cerr = (whole_reg >= WHOLE_CAP) ? ERR_BAD_WHOLE : ERR_NO_DOT;
                    PH_DOT:     cerr = ERR_NO_DOT;
                    default:    cerr = ERR_SHORT_FRAC;
                endcase
                if (nonempty_reg)
                begin
                    ovalid_next = 1'b1;
                    oline_next  = cur_line;
                    oerr_next   = cerr;
                    if (cerr != ERR_OK)
                    begin
                        halt_next = 1'b1;
                        ocmd_next = '0;
                        ox_next   = '0;
                        oy_next   = '0;
                        oz_next   = '0;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        ocmd_next  = CMD_OUT_BITS'(num_reg);
                        ox_next    = coord_reg[0];
                        oy_next    = coord_reg[1];
                        oz_next    = coord_reg[2];
                    end
                end
                lcnt_next     = cur_line;
                phase_next    = PH_N;
                nonempty_next = 1'b0;
                num_next      = '0;
                whole_next    = '0;
                minus_next    = 1'b0;
                wneg_next     = 1'b0;
                frac_next     = '0;
                fchars_next   = '0;
                fstage_next   = '0;
                fneg_next     = 1'b0;
                fgot_next     = 1'b0;
                axis_next     = '0;
                seen_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_N;
            lcnt_reg     <= '0;
            nonempty_reg <= 1'b0;
            num_reg      <= '0;
            whole_reg    <= '0;
            minus_reg    <= 1'b0;
            wneg_reg     <= 1'b0;
            frac_reg     <= '0;
            fchars_reg   <= '0;
            fstage_reg   <= '0;
            fneg_reg     <= 1'b0;
            fgot_reg     <= 1'b0;
            axis_reg     <= '0;
            seen_reg     <= '0;
            coord_reg    <= '{default: '0};
            first_reg    <= 1'b0;
            halt_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            lcnt_reg     <= lcnt_next;
            nonempty_reg <= nonempty_next;
            num_reg      <= num_next;
            whole_reg    <= whole_next;
            minus_reg    <= minus_next;
            wneg_reg     <= wneg_next;
            frac_reg     <= frac_next;
            fchars_reg   <= fchars_next;
            fstage_reg   <= fstage_next;
            fneg_reg     <= fneg_next;
            fgot_reg     <= fgot_next;
            axis_reg     <= axis_next;
            seen_reg     <= seen_next;
            coord_reg    <= coord_next;
            first_reg    <= first_next;
            halt_reg     <= halt_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ocmd_reg  <= ocmd_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        oline_reg <= oline_next;
        oerr_reg  <= oerr_next;
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.command_number = ocmd_reg;
    assign out_ch.x_milli        = ox_reg;
    assign out_ch.y_milli        = oy_reg;
    assign out_ch.z_milli        = oz_reg;
    assign out_ch.line_number    = oline_reg;
    assign out_ch.error_code     = oerr_reg;

endmodule

[rtl/gcode_move_line_parser_top.sv]
// ----------------------------------------------------------------------------
// gcode_move_line_parser_top
// Streaming parser of N<num> G01 [X][Y][Z] lines into fixed-point commands.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; a CR followed by an
//   ordinary byte holds off the next byte in the front (the held CR is replayed
//   as its own token). A result waiting on out_ch stalls the parser; the 4-entry
//   queue then fills.
// Flow: a byte is queued when accepted and parsed once it heads the queue and
//   out_ch is free; the edge that parses a line's LF also registers its result.
// Reset: rst_n clears all control state, coordinates and the sticky error.
// ----------------------------------------------------------------------------
module gcode_move_line_parser_top
    import gmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gmlp_in_if.sink     in_ch,
    gmlp_out_if.source  out_ch
);

    // front -> queue
    logic   push;
    token_t push_tok;
    logic   full;

    // queue -> back
    logic   tok_valid;
    token_t tok;
    logic   pop;

    // Front: takes each transaction, keeps the held-CR state.
    gmlp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .push     (push),
        .push_tok (push_tok),
        .full     (full)
    );

    // Short queue decouples the byte feed from result back-pressure.
    gmlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .pop       (pop)
    );

    // Back: line state machine and output register.
    gmlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

[verif/tb_gcode_move_line_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_gcode_move_line_parser_top
// Self-checking bench for the G-code move line parser: a directed table of
// lines, then random well-formed lines ending in one broken line, scored
// against an in-bench line predictor with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_gcode_move_line_parser_top;
    import gmlp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CMD_MAX    = (64'd1 << COMMAND_NUMBER_BITS) - 1;
    localparam int     LINE_MAX   = (1 << LINE_COUNT_BITS) - 1;
    localparam int     NUM_RANDOM = 1400;

    // parser phases of the predictor
    typedef enum int {
        P_N, P_NUM_START, P_NUM_SIGN, P_NUM_DIG, P_G, P_G0, P_G1, P_AXIS,
        P_AFTER_LETTER, P_W_START, P_W_SIGN, P_W_DIG, P_DOT, P_FRAC
    } phase_t;

    typedef struct {
        logic [CMD_OUT_BITS-1:0]      cmd;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [LINE_COUNT_BITS-1:0]   line;
        err_t                         err;
    } move_t;

    typedef struct {
        string text;     // '~' stands for a NUL byte
        bit    eof_end;  // close the line by end of file
        bit    typed;    // expectation below is written out by hand
        move_t want;
    } row_t;

    logic clk;
    logic rst_n;

    gmlp_in_if  in_ch ();
    gmlp_out_if out_ch ();

    gcode_move_line_parser_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #1ns;
        clk = 1'b1;
        #1ns;
    end

    // ------------------------------------------------------------------
    // Line predictor state
    // ------------------------------------------------------------------
    phase_t      pstate;
    int unsigned lcount;
    bit          nonempty, cr_pend, minus_dir, wneg, fneg, fgot, first_ok, stuck;
    longint      nacc;
    int          wacc, facc, fcnt, axis, fstage;
    bit [2:0]    seen;
    int          coord [3];

    move_t  pending_moves [$];   // expected results, oldest first
    int     fail_count;
    bit     gaps_on;             // random idling enabled
    bit     hold_req;            // ask receiver for a long hold-off
    bit     use_typed;
    move_t  typed_move;

    function automatic bit is_d(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_w(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_line();
        pstate = P_N; nonempty = 0; cr_pend = 0; nacc = 0; wacc = 0;
        minus_dir = 0; wneg = 0; facc = 0; fcnt = 0; axis = 0; seen = 0;
        fstage = 0; fneg = 0; fgot = 0;
    endfunction

    function automatic move_t make_move(longint cmd, bit zero, err_t e);
        move_t m;
        m.cmd  = cmd[CMD_OUT_BITS-1:0];
        m.x    = zero ? '0 : coord[0][COORD_BITS-1:0];
        m.y    = zero ? '0 : coord[1][COORD_BITS-1:0];
        m.z    = zero ? '0 : coord[2][COORD_BITS-1:0];
        m.line = LINE_COUNT_BITS'((lcount < LINE_MAX) ? lcount + 1 : LINE_MAX);
        m.err  = e;
        return m;
    endfunction

    function automatic bit num_ok();
        return nacc >= 1 && nacc <= CMD_MAX;
    endfunction

    function automatic err_t end_coord();
        int v;
        if (!fgot || (fneg && facc != 0)) return ERR_BAD_FRAC;
        if (axis == 0 && seen[2:1] != 0) return ERR_AXIS_ORDER;
        if (axis == 1 && seen[2]) return ERR_AXIS_ORDER;
        v = wneg ? -(wacc * 1000) : wacc * 1000;
        v = minus_dir ? v - facc : v + facc;
        coord[axis] = v;
        seen[axis] = 1'b1;
        pstate = P_AXIS;
        return ERR_OK;
    endfunction

    function automatic void frac_char(logic [7:0] c);
        case (fstage)
            0:
            begin
                if (is_w(c)) ;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    fneg = (c == CH_MINUS); fstage = 1;
                end
                else if (is_d(c))
                begin
                    facc = c - CH_0; fgot = 1; fstage = 2;
                end
                else fstage = 3;
            end
            1:
            begin
                if (is_d(c))
                begin
                    facc = c - CH_0; fgot = 1; fstage = 2;
                end
                else fstage = 3;
            end
            2:
            begin
                if (is_d(c)) facc = facc * 10 + (c - CH_0);
                else fstage = 3;
            end
            default: ;
        endcase
    endfunction

    // one content byte; a number's terminator falls through to the next phase
    function automatic err_t feed_char(logic [7:0] c);
        longint t;
        nonempty = 1;
        forever
        begin
            case (pstate)
                P_N:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_N) begin pstate = P_NUM_START; return ERR_OK; end
                    return ERR_NO_N;
                end
                P_NUM_START:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_PLUS) begin pstate = P_NUM_SIGN; return ERR_OK; end
                    if (is_d(c))
                    begin
                        nacc = c - CH_0; pstate = P_NUM_DIG; return ERR_OK;
                    end
                    return ERR_BAD_NUMBER;
                end
                P_NUM_SIGN:
                begin
                    if (is_d(c))
                    begin
                        nacc = c - CH_0; pstate = P_NUM_DIG; return ERR_OK;
                    end
                    return ERR_BAD_NUMBER;
                end
                P_NUM_DIG:
                begin
                    if (is_d(c))
                    begin
                        t = nacc * 10 + (c - CH_0);
                        nacc = (t > CMD_MAX + 1) ? CMD_MAX + 1 : t;
                        return ERR_OK;
                    end
                    if (!num_ok()) return ERR_BAD_NUMBER;
                    pstate = P_G;
                end
                P_G:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_G) begin pstate = P_G0; return ERR_OK; end
                    return ERR_NOT_G01;
                end
                P_G0:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_0) begin pstate = P_G1; return ERR_OK; end
                    return ERR_NOT_G01;
                end
                P_G1:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_1) begin pstate = P_AXIS; return ERR_OK; end
                    return ERR_NOT_G01;
                end
                P_AXIS:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c < CH_X || c > CH_Z) return ERR_BAD_LETTER;
                    axis = c - CH_X; wacc = 0; wneg = 0; minus_dir = 0;
                    pstate = P_AFTER_LETTER;
                    return ERR_OK;
                end
                P_AFTER_LETTER:
                begin
                    minus_dir = (c == CH_MINUS);
                    pstate = P_W_START;
                end
                P_W_START:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        wneg = (c == CH_MINUS); pstate = P_W_SIGN; return ERR_OK;
                    end
                    if (is_d(c))
                    begin
                        wacc = c - CH_0; pstate = P_W_DIG; return ERR_OK;
                    end
                    return ERR_BAD_WHOLE;
                end
                P_W_SIGN:
                begin
                    if (is_d(c))
                    begin
                        wacc = c - CH_0; pstate = P_W_DIG; return ERR_OK;
                    end
                    return ERR_BAD_WHOLE;
                end
                P_W_DIG:
                begin
                    if (is_d(c))
                    begin
                        wacc = wacc * 10 + (c - CH_0);
                        if (wacc > 1000) wacc = 1000;
                        return ERR_OK;
                    end
                    if (wacc >= 1000) return ERR_BAD_WHOLE;
                    pstate = P_DOT;
                end
                P_DOT:
                begin
                    if (is_w(c)) return ERR_OK;
                    if (c != CH_DOT) return ERR_NO_DOT;
                    facc = 0; fcnt = 0; fstage = 0; fneg = 0; fgot = 0;
                    pstate = P_FRAC;
                    return ERR_OK;
                end
                default:
                begin
                    if (c == CH_NUL) fstage = 3;
                    else frac_char(c);
                    fcnt++;
                    if (fcnt >= 3) return end_coord();
                    return ERR_OK;
                end
            endcase
        end
    endfunction

    function automatic err_t close_code();
        case (pstate)
            P_N:                              return ERR_NO_N;
            P_NUM_START, P_NUM_SIGN:          return ERR_BAD_NUMBER;
            P_NUM_DIG:                        return num_ok() ? ERR_NOT_G01 : ERR_BAD_NUMBER;
            P_G, P_G0, P_G1:                  return ERR_NOT_G01;
            P_AXIS:
            begin
                if (seen == 0) return ERR_NO_AXES;
                if (!first_ok && seen != 3'b111) return ERR_FIRST_INCOMPLETE;
                return ERR_OK;
            end
            P_AFTER_LETTER, P_W_START, P_W_SIGN: return ERR_BAD_WHOLE;
            P_W_DIG:                          return wacc >= 1000 ? ERR_BAD_WHOLE : ERR_NO_DOT;
            P_DOT:                            return ERR_NO_DOT;
            default:                          return ERR_SHORT_FRAC;
        endcase
    endfunction

    function automatic bit end_line(output move_t m);
        err_t e;
        bit   got;
        got = 0;
        if (nonempty)
        begin
            e = close_code();
            if (e != ERR_OK)
            begin
                m = make_move(0, 1, e);
                stuck = 1;
            end
            else
            begin
                first_ok = 1;
                m = make_move(nacc, 0, ERR_OK);
            end
            got = 1;
        end
        if (lcount < LINE_MAX) lcount++;
        clear_line();
        return got;
    endfunction

    // one accepted transaction; returns 1 when it yields a result
    function automatic bit parse_step(logic [7:0] c, logic eof, output move_t m);
        err_t e;
        e = ERR_OK;
        if (stuck) return 0;
        if (eof) return (nonempty || cr_pend) ? end_line(m) : 0;
        if (c == CH_LF) return end_line(m);
        if (c == CH_CR)
        begin
            if (cr_pend) e = feed_char(CH_CR);
            cr_pend = 1;
        end
        else
        begin
            if (cr_pend)
            begin
                cr_pend = 0;
                e = feed_char(CH_CR);
            end
            if (e == ERR_OK) e = feed_char(c);
        end
        if (e != ERR_OK)
        begin
            m = make_move(0, 1, e);
            stuck = 1;
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Sender: inputs change on the falling edge, valid held across items
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] c, logic eof);
        move_t m;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_in     <= c;
        in_ch.end_of_file <= eof;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        if (parse_step(c, eof, m))
        begin
            if (use_typed) m = typed_move;
            pending_moves = {pending_moves, m};
        end
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            send_byte(c == "~" ? CH_NUL : c, 1'b0);
        end
    endtask

    function automatic string rand_ws(int most);
        string s;
        s = "";
        repeat ($urandom_range(0, most))
            s = {s, ($urandom_range(0, 3) == 0) ? "\t" : " "};
        return s;
    endfunction

    // any byte but a digit, LF or CR
    function automatic string odd_byte();
        byte b;
        do b = byte'($urandom_range(0, 255));
        while (b == 10 || b == 13 || (b >= "0" && b <= "9"));
        return (b == 0) ? "~" : string'(b);
    endfunction

    function automatic string dig();
        return $sformatf("%0d", $urandom_range(0, 9));
    endfunction

    // three bytes after the dot that always read as a valid fraction
    function automatic string frac_window();
        case ($urandom_range(0, 5))
            0:       return {dig(), dig(), dig()};
            1:       return {" ", dig(), dig()};
            2:       return {"+", dig(), odd_byte()};
            3:       return {"-0", odd_byte()};
            4:       return {dig(), odd_byte(), odd_byte()};
            default: return {dig(), "~~"};
        endcase
    endfunction

    function automatic string coord_field(int ax);
        string pre [5] = '{"", "-", "+", " -", " "};
        string w;
        w = $sformatf("%0d", $urandom_range(0, 999));
        if ($urandom_range(0, 4) == 0) w = {"0", w};
        return {rand_ws(1), string'(byte'("X" + ax)), pre[$urandom_range(0, 4)], w,
                rand_ws(1), ".", frac_window()};
    endfunction

    function automatic string good_line();
        string  s;
        longint n;
        int     pick;
        case ($urandom_range(0, 5))
            0:       n = CMD_MAX;
            1:       n = 1;
            default: n = $urandom_range(1, 99999);
        endcase
        s = {rand_ws(2), "N", ($urandom_range(0, 5) == 0) ? "+" : "", $sformatf("%0d", n),
             rand_ws(2), " G", rand_ws(1), "0", rand_ws(1), "1"};
        pick = first_ok ? $urandom_range(1, 7) : 7;
        for (int ax = 0; ax < 3; ax++)
            if (pick[ax])
            begin
                s = {s, coord_field(ax)};
                if ($urandom_range(0, 7) == 0) s = {s, coord_field(ax)};
            end
        return {s, rand_ws(2)};
    endfunction

    function automatic string bad_line();
        case ($urandom_range(1, 10))
            1:       return "Q";
            2:       return "N0 ";
            3:       return "N5 G02";
            4:       return "N5 G01 A";
            5:       return "N5 G01 X1000.000";
            6:       return "N5 G01 X5 ";
            7:       return "N5 G01 X5.1";
            8:       return "N5 G01 X5.ab";
            9:       return "N5 G01 Y1.000 X1.000";
            default: return "N5 G01";
        endcase
    endfunction

    task automatic check_move(move_t got);
        move_t w;
        if (pending_moves.size() == 0)
        begin
            $error("result with none expected: line %0d err %0d", got.line, got.err);
            fail_count++;
            return;
        end
        w = pending_moves.pop_front();
        if (got.cmd !== w.cmd)
        begin
            $error("command_number exp %0d got %0d", w.cmd, got.cmd); fail_count++;
        end
        if (got.x !== w.x)
        begin
            $error("x_milli exp %0d got %0d", w.x, got.x); fail_count++;
        end
        if (got.y !== w.y)
        begin
            $error("y_milli exp %0d got %0d", w.y, got.y); fail_count++;
        end
        if (got.z !== w.z)
        begin
            $error("z_milli exp %0d got %0d", w.z, got.z); fail_count++;
        end
        if (got.line !== w.line)
        begin
            $error("line_number exp %0d got %0d", w.line, got.line); fail_count++;
        end
        if (got.err !== w.err)
        begin
            $error("error_code exp %0d got %0d", w.err, got.err); fail_count++;
        end
    endtask

    // results are sampled on the rising edge
    always @(posedge clk)
    begin
        move_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.cmd  = out_ch.command_number;
            got.x    = out_ch.x_milli;
            got.y    = out_ch.y_milli;
            got.z    = out_ch.z_milli;
            got.line = out_ch.line_number;
            got.err  = err_t'(out_ch.error_code);
            check_move(got);
        end
    end

    // Receiver: random ready bursts, and one long hold-off on request
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_req = 0;
                repeat (300) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("gcode_move_line_parser_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        row_t dir_rows [$];
        row_t r;
        int   sent;
        bit   hold_done;
        in_ch.valid       = 1'b0;
        in_ch.char_in     = '0;
        in_ch.end_of_file = 1'b0;
        rst_n      = 1'b0;
        fail_count = 0;
        gaps_on    = 1;
        hold_req   = 0;
        hold_done  = 0;
        use_typed  = 0;
        stuck = 0; first_ok = 0; lcount = 0;
        coord[0] = 0; coord[1] = 0; coord[2] = 0;
        clear_line();

        // Extremes of X and Y and a zero Z on the first line, then N at its top
        // with a negative fraction only; Y and Z carry over.
        r = '{text: "N1 G01 X999.999 Y-999.999 Z0.000\n", eof_end: 0, typed: 1,
              want: '{1, 999999, -999999, 0, 1, ERR_OK}};
        dir_rows = {dir_rows, r};
        r = '{text: "N2147483647 G01 X-0.001\r\n", eof_end: 0, typed: 1,
              want: '{CMD_MAX, -1, -999999, 0, 2, ERR_OK}};
        dir_rows = {dir_rows, r};
        r.typed = 0;
        r.eof_end = 0;
        // blank lines, bare and with a CR, are counted only
        r.text = "\n";                                   dir_rows = {dir_rows, r};
        r.text = "\r\n";                                 dir_rows = {dir_rows, r};
        // lone CRs act as whitespace
        r.text = "N3\rG01\rX1.000\r\r\n";                dir_rows = {dir_rows, r};
        r.text = "N+4 G01 Z+5.+12\n";                    dir_rows = {dir_rows, r};
        r.text = "  N5 G 0 1 X 7 . 05  Y -3.250\n";      dir_rows = {dir_rows, r};
        // NUL ends the fraction read; high bytes after a digit
        r.text = "N6 G01 Y3.4~~\n";                      dir_rows = {dir_rows, r};
        r.text = {"N7 G01 Z-2.9", string'(8'hFF), string'(8'h80), "\n"};
        dir_rows = {dir_rows, r};
        // repeated axis, minus zero fraction
        r.text = "N8 G01 X1.000 X-2.-0z Z0999.999\n";    dir_rows = {dir_rows, r};
        // end of file closes a line, with and without a held CR
        r.eof_end = 1;
        r.text = "N9 G01 Y12.345";                       dir_rows = {dir_rows, r};
        r.text = "N10 G01 Z1.000\r";                     dir_rows = {dir_rows, r};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            use_typed  = dir_rows[i].typed;
            typed_move = dir_rows[i].want;
            send_text(dir_rows[i].text);
            if (dir_rows[i].eof_end) send_byte($urandom_range(0, 255), 1'b1);
            use_typed = 0;
        end
        // end of file with nothing pending is ignored
        send_byte(8'h0A, 1'b1);

        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            string s;
            if (sent > NUM_RANDOM * 85 / 100) gaps_on = 0;
            if (sent > 300 && !hold_done)
            begin
                hold_req  = 1;
                hold_done = 1;
            end
            case ($urandom_range(0, 15))
                0:       s = "\n";
                1:       s = "\r\n";
                default: s = {good_line(), ($urandom_range(0, 2) == 0) ? "\r\n" : "\n"};
            endcase
            if ($urandom_range(0, 19) == 0 && s.len() > 2)
            begin
                // close by end of file instead of LF
                send_text(s.substr(0, s.len() - 2));
                send_byte($urandom_range(0, 255), 1'b1);
            end
            else
                send_text(s);
            sent += s.len();
        end
        // one broken line: the error is sticky, so it comes last
        send_text({bad_line(), "\n"});
        send_text("N1 G01 X1.000 Y1.000 Z1.000\n");
        in_ch.valid <= 1'b0;

        wait (pending_moves.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("gcode_move_line_parser_top verification clean");
        else
            $display("gcode_move_line_parser_top verification failed");
        $finish;
    end

endmodule
